>>> rtl/mokl_pkg.sv
// ----------------------------------------------------------------------------
// mokl_pkg
// Shared types and constants for the mean-of-k-lowest block.
// ----------------------------------------------------------------------------
package mokl_pkg;

	localparam int RUNS_W    = 16;  // runs_per_group register
	localparam int KEEP_W    = 5;   // keep_count register
	localparam int KT_W      = 5;   // kept_total result field
	localparam int CFG_W     = 16;  // widest register
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_RUNS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP = 4'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SUM,
		ST_DSTART,
		ST_DIV
	} state_t;

endpackage

>>> rtl/mokl_channels.sv
// ----------------------------------------------------------------------------
// mokl channels
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface sample_if #(
	parameter int TW = 32
);
	logic          valid;
	logic          ready;
	logic [TW-1:0] sample_time;

	modport source (output valid, output sample_time, input ready);
	modport sink   (input valid, input sample_time, output ready);
endinterface

interface result_if #(
	parameter int TW = 32,
	parameter int KW = 5
);
	logic          valid;
	logic          ready;
	logic [TW-1:0] group_mean;
	logic [KW-1:0] kept_total;

	modport source (output valid, output group_mean, output kept_total, input ready);
	modport sink   (input valid, input group_mean, input kept_total, output ready);
endinterface

>>> rtl/mokl_ram.sv
// ----------------------------------------------------------------------------
// mokl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mokl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mokl_div.sv
// ----------------------------------------------------------------------------
// mokl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mokl_div #(
	parameter int NUM_W = 37,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic           fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> rtl/mean_of_k_lowest_per_group.sv
// ----------------------------------------------------------------------------
// mean_of_k_lowest_per_group
// Keeps the keep_count smallest samples of each group in a RAM and emits
// the truncated mean of the kept samples on the last sample of a group.
//
//  channel   dir  payload                    handshake
//  samples   in   sample_time                valid/ready
//  results   out  group_mean, kept_total     valid/ready
//  wr_*      in   wr_index, wr_data          wr_en, no stall
//
// A sample that is appended, or that changes nothing, needs no rescan.
// A sample that replaces the largest kept entry makes the RAM read port
// rescan the store for the new largest entry.
// The last sample of a group sums the n kept entries over the read port,
// then runs the bit-serial divider, then loads the result register once
// that register is free.
// No clearing pass after reset; a waiting result does not block samples
// until the next group end needs the output register.
// ----------------------------------------------------------------------------
module mean_of_k_lowest_per_group #(
	parameter int MAX_KEEP   = 16,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mokl_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [mokl_pkg::CFG_W-1:0]     wr_data,
	sample_if.sink                        samples,
	result_if.source                      results
);

	localparam int CNT_W = $clog2(MAX_KEEP + 1);
	localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int SUM_W = TIME_WIDTH + CNT_W;

	mokl_pkg::state_t state_q, state_d;

	logic [mokl_pkg::RUNS_W-1:0] runs_q;
	logic [mokl_pkg::KEEP_W-1:0] keep_q;

	logic [CNT_W-1:0]            stored_q;
	logic [IDX_W-1:0]            slot_q;
	logic [TIME_WIDTH-1:0]       lval_q;
	logic [mokl_pkg::RUNS_W-1:0] run_q;
	logic [CNT_W-1:0]            tgt_q;
	logic [CNT_W-1:0]            rd_ptr_q;
	logic                        vld_s1;
	logic [CNT_W-1:0]            idx_s1;
	logic [SUM_W-1:0]            sum_q;

	logic                        out_vld_q;
	logic [TIME_WIDTH-1:0]       mean_q;
	logic [mokl_pkg::KT_W-1:0]   kept_q;

	logic [CNT_W-1:0]            limit;
	logic [mokl_pkg::RUNS_W-1:0] grp_len;
	logic [mokl_pkg::RUNS_W-1:0] run_nxt;
	logic                        grp_end;
	logic                        accept;
	logic                        append;
	logic                        replace;
	logic                        issue;
	logic                        last_s1;
	logic                        out_free;
	logic                        div_start;
	logic                        div_done;
	logic                        out_load;
	logic [SUM_W-1:0]            quot;

	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [TIME_WIDTH-1:0]       ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_q <= mokl_pkg::RUNS_W'(1);
			keep_q <= mokl_pkg::KEEP_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				mokl_pkg::REG_RUNS: runs_q <= wr_data[mokl_pkg::RUNS_W-1:0];
				mokl_pkg::REG_KEEP: keep_q <= wr_data[mokl_pkg::KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective limits
	always_comb begin
		if (keep_q == '0) begin
			limit = CNT_W'(1);
		end else if (int'(keep_q) > MAX_KEEP) begin
			limit = CNT_W'(MAX_KEEP);
		end else begin
			limit = CNT_W'(keep_q);
		end
	end

	assign grp_len  = (runs_q == '0) ? mokl_pkg::RUNS_W'(1) : runs_q;
	assign run_nxt  = run_q + 1'b1;
	assign grp_end  = (run_nxt == '0) || (run_nxt >= grp_len);

	assign accept   = samples.valid && samples.ready;
	assign append   = stored_q < limit;
	assign replace  = !append && (stored_q != '0) && (samples.sample_time < lval_q);

	assign issue    = rd_ptr_q < tgt_q;
	assign last_s1  = vld_s1 && (idx_s1 == tgt_q - 1'b1);
	assign out_free = !out_vld_q || results.ready;

	assign ram_we    = accept && (append || replace);
	assign ram_waddr = append ? stored_q[IDX_W-1:0] : slot_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mokl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			mokl_pkg::ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					if (grp_end) begin
						state_d = mokl_pkg::ST_SUM;
					end else if (replace) begin
						state_d = mokl_pkg::ST_SCAN;
					end
				end
			end
			mokl_pkg::ST_SCAN: begin
				if (last_s1) begin
					state_d = mokl_pkg::ST_IDLE;
				end
			end
			mokl_pkg::ST_SUM: begin
				if (last_s1) begin
					state_d = mokl_pkg::ST_DSTART;
				end
			end
			mokl_pkg::ST_DSTART: begin
				div_start = 1'b1;
				state_d   = mokl_pkg::ST_DIV;
			end
			mokl_pkg::ST_DIV: begin
				if (div_done && out_free) begin
					out_load = 1'b1;
					state_d  = mokl_pkg::ST_IDLE;
				end
			end
			default: state_d = mokl_pkg::ST_IDLE;
		endcase
	end

	// Store bookkeeping and read sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			slot_q   <= '0;
			run_q    <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
		end else if (state_q == mokl_pkg::ST_IDLE) begin
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			if (accept) begin
				run_q <= grp_end ? '0 : run_nxt;
				if (grp_end) begin
					stored_q <= '0;
					slot_q   <= '0;
				end else if (append) begin
					stored_q <= stored_q + 1'b1;
					// newest index wins a tie for largest
					if (stored_q == '0 || samples.sample_time >= lval_q) begin
						slot_q <= stored_q[IDX_W-1:0];
					end
				end
			end
		end else if (state_q == mokl_pkg::ST_SCAN || state_q == mokl_pkg::ST_SUM) begin
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			vld_s1 <= issue;
			if (state_q == mokl_pkg::ST_SCAN && vld_s1 &&
			    (idx_s1 == '0 || ram_rdata >= lval_q)) begin
				slot_q <= idx_s1[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mokl_pkg::ST_IDLE) begin
			sum_q <= '0;
			if (accept) begin
				if (grp_end) begin
					tgt_q <= append ? stored_q + 1'b1 : stored_q;
				end else begin
					tgt_q <= stored_q;
				end
				if (append && (stored_q == '0 || samples.sample_time >= lval_q)) begin
					lval_q <= samples.sample_time;
				end
			end
		end else begin
			idx_s1 <= rd_ptr_q;
			if (vld_s1) begin
				if (state_q == mokl_pkg::ST_SCAN) begin
					if (idx_s1 == '0 || ram_rdata >= lval_q) begin
						lval_q <= ram_rdata;
					end
				end else if (state_q == mokl_pkg::ST_SUM) begin
					sum_q <= sum_q + SUM_W'(ram_rdata);
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_q <= quot[TIME_WIDTH-1:0];
			kept_q <= mokl_pkg::KT_W'({{mokl_pkg::KT_W{1'b0}}, tgt_q});
		end
	end

	assign results.valid      = out_vld_q;
	assign results.group_mean = mean_q;
	assign results.kept_total = kept_q;

	mokl_ram #(
		.WIDTH (TIME_WIDTH),
		.DEPTH (MAX_KEEP)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (samples.sample_time),
		.raddr (rd_ptr_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	mokl_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_q),
		.den    (tgt_q),
		.done   (div_done),
		.quot   (quot)
	);

`ifndef SYNTH
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && append && !grp_end) |=> (stored_q == $past(stored_q) + 1'b1))
		else $error("stored count did not advance on append");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mokl_pkg::ST_IDLE && stored_q != '0) |->
		(CNT_W'(slot_q) < stored_q))
		else $error("largest slot outside held entries");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (tgt_q != '0))
		else $error("mean started over an empty store");
`endif

endmodule
